@@ hw/rtl/esc_pkg.sv @@
// esc_pkg: shared types and constants for the epoch seconds to calendar block
// controller state, datapath command and status structs, calendar lengths in seconds
// no dependencies
package esc_pkg;

  localparam int unsigned YEAR_WIDTH = 16;

  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_365D     = 32'd31536000;
  localparam logic [31:0] SECS_366D     = 32'd31622400;
  localparam logic [31:0] SECS_28D      = 32'd2419200;
  localparam logic [31:0] SECS_29D      = 32'd2505600;
  localparam logic [31:0] SECS_30D      = 32'd2592000;
  localparam logic [31:0] SECS_31D      = 32'd2678400;

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MINUTE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_HOUR,
    OP_MINUTE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic ge;
  } dp_status_t;

  // length of month m (0 = january) in seconds
  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] len;
    case (m) inside
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = SECS_31D;
      MONTH_FEB:                                 len = leap ? SECS_29D : SECS_28D;
      default:                                   len = SECS_30D;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/esc_ctrl.sv @@
// esc_ctrl: sequencer for the calendar scan
// walks years, months, days, hours and minutes; owns the output valid flag
// depends on esc_pkg
module esc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  esc_pkg::dp_status_t status,
  output esc_pkg::dp_cmd_t    cmd
);

  esc_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= esc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      esc_pkg::ST_IDLE: begin
        if (in_valid) state_next = esc_pkg::ST_YEAR;
      end
      esc_pkg::ST_YEAR: begin
        if (!status.ge) state_next = esc_pkg::ST_MONTH;
      end
      esc_pkg::ST_MONTH: begin
        if (!status.ge) state_next = esc_pkg::ST_DAY;
      end
      esc_pkg::ST_DAY: begin
        if (!status.ge) state_next = esc_pkg::ST_HOUR;
      end
      esc_pkg::ST_HOUR: begin
        if (!status.ge) state_next = esc_pkg::ST_MINUTE;
      end
      esc_pkg::ST_MINUTE: begin
        if (!status.ge) state_next = out_free ? esc_pkg::ST_IDLE : esc_pkg::ST_DONE;
      end
      esc_pkg::ST_DONE: begin
        if (out_free) state_next = esc_pkg::ST_IDLE;
      end
      default: state_next = esc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.op      = esc_pkg::OP_NONE;
    cmd.capture = 1'b0;
    unique case (state)
      esc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = esc_pkg::OP_LOAD;
      end
      esc_pkg::ST_YEAR:  cmd.op = esc_pkg::OP_YEAR;
      esc_pkg::ST_MONTH: cmd.op = esc_pkg::OP_MONTH;
      esc_pkg::ST_DAY:   cmd.op = esc_pkg::OP_DAY;
      esc_pkg::ST_HOUR:  cmd.op = esc_pkg::OP_HOUR;
      esc_pkg::ST_MINUTE: begin
        cmd.op      = esc_pkg::OP_MINUTE;
        cmd.capture = !status.ge && out_free;
      end
      esc_pkg::ST_DONE: cmd.capture = out_free;
      default: cmd.op = esc_pkg::OP_NONE;
    endcase
  end

endmodule

@@ hw/rtl/esc_dpath.sv @@
// esc_dpath: remaining-seconds register, calendar counters and result registers
// one compare and subtract per cycle against the current unit length
// depends on esc_pkg
module esc_dpath #(
  parameter int unsigned EPOCH_YEAR    = 1970,
  parameter int unsigned SECONDS_WIDTH = 32
) (
  input  logic                     clk,
  input  logic [SECONDS_WIDTH-1:0] epoch_seconds,
  input  esc_pkg::dp_cmd_t         cmd,
  output esc_pkg::dp_status_t      status,
  output logic [11:0]              cal_year,
  output logic [3:0]               cal_month,
  output logic [4:0]               cal_day,
  output logic [4:0]               cal_hour,
  output logic [5:0]               cal_minute,
  output logic [5:0]               cal_second
);

  localparam int unsigned YW = esc_pkg::YEAR_WIDTH;
  localparam logic [YW-1:0] YEAR_INIT   = YW'(EPOCH_YEAR);
  localparam logic [6:0]    MOD100_INIT = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]    MOD400_INIT = 9'(EPOCH_YEAR % 400);

  logic [SECONDS_WIDTH-1:0] t;
  logic [YW-1:0]            year;
  logic [6:0]               mod100;
  logic [8:0]               mod400;
  logic [3:0]               month;
  logic [4:0]               day;
  logic [4:0]               hour;
  logic [5:0]               minute;

  logic                     leap;
  logic [31:0]              len;
  logic                     ge;

  assign leap = ((year[1:0] == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);

  always_comb begin
    len = 32'd0;
    ge  = 1'b0;
    case (cmd.op)
      esc_pkg::OP_YEAR: begin
        len = leap ? esc_pkg::SECS_366D : esc_pkg::SECS_365D;
        ge  = t >= SECONDS_WIDTH'(len);
      end
      esc_pkg::OP_MONTH: begin
        len = esc_pkg::month_secs(month, leap);
        ge  = (t >= SECONDS_WIDTH'(len)) && (month != esc_pkg::MONTH_LAST);
      end
      esc_pkg::OP_DAY: begin
        len = esc_pkg::SECS_PER_DAY;
        ge  = t >= SECONDS_WIDTH'(len);
      end
      esc_pkg::OP_HOUR: begin
        len = esc_pkg::SECS_PER_HOUR;
        ge  = t >= SECONDS_WIDTH'(len);
      end
      esc_pkg::OP_MINUTE: begin
        len = esc_pkg::SECS_PER_MIN;
        ge  = t >= SECONDS_WIDTH'(len);
      end
      default: begin
        len = 32'd0;
        ge  = 1'b0;
      end
    endcase
  end

  assign status.ge = ge;

  always_ff @(posedge clk) begin
    if (cmd.op == esc_pkg::OP_LOAD) begin
      t      <= epoch_seconds;
      year   <= YEAR_INIT;
      mod100 <= MOD100_INIT;
      mod400 <= MOD400_INIT;
      month  <= 4'd0;
      day    <= 5'd0;
      hour   <= 5'd0;
      minute <= 6'd0;
    end else if (ge) begin
      t <= t - SECONDS_WIDTH'(len);
      case (cmd.op)
        esc_pkg::OP_YEAR: begin
          year   <= year + YW'(1);
          mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
        end
        esc_pkg::OP_MONTH:  month  <= month + 4'd1;
        esc_pkg::OP_DAY:    day    <= day + 5'd1;
        esc_pkg::OP_HOUR:   hour   <= hour + 5'd1;
        esc_pkg::OP_MINUTE: minute <= minute + 6'd1;
        default: ;
      endcase
    end
  end

  // result register, parts the scan from the output channel
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cal_year   <= year[11:0];
      cal_month  <= month + 4'd1;
      cal_day    <= day + 5'd1;
      cal_hour   <= hour;
      cal_minute <= minute;
      cal_second <= t[5:0];
    end
  end

endmodule

@@ hw/rtl/epoch_seconds_to_calendar_core.sv @@
// epoch_seconds_to_calendar_core: top level of the epoch seconds to calendar converter
// joins the sequencer esc_ctrl and the datapath esc_dpath; depends on esc_pkg
//
// Converts a count of seconds since midnight, 1 January of EPOCH_YEAR, into the Gregorian
// year, month, day, hour, minute and second. One item is in work at a time. The scan
// removes whole years, then whole months into the year (at most 11), whole days into the
// month, hours and minutes; an item cannot finish while an earlier result still holds the
// output register. The datapath has a single compare-and-subtract unit, which removes one
// year, month, day, hour or minute per cycle. A finished result sits in an output register,
// so the next item is taken while it waits. The year keeps its low 12 bits on the output.
module epoch_seconds_to_calendar_core #(
  parameter int unsigned EPOCH_YEAR    = 1970,
  parameter int unsigned SECONDS_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SECONDS_WIDTH-1:0] epoch_seconds,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [11:0]              cal_year,
  output logic [3:0]               cal_month,
  output logic [4:0]               cal_day,
  output logic [4:0]               cal_hour,
  output logic [5:0]               cal_minute,
  output logic [5:0]               cal_second
);

  esc_pkg::dp_cmd_t    cmd;
  esc_pkg::dp_status_t status;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  esc_dpath #(
    .EPOCH_YEAR    (EPOCH_YEAR),
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .epoch_seconds (epoch_seconds),
    .cmd           (cmd),
    .status        (status),
    .cal_year      (cal_year),
    .cal_month     (cal_month),
    .cal_day       (cal_day),
    .cal_hour      (cal_hour),
    .cal_minute    (cal_minute),
    .cal_second    (cal_second)
  );

endmodule

@@ hw/rtl/esc_checker.sv @@
// esc_checker: port-level assertions for epoch_seconds_to_calendar_core
// bound to the top level; no package dependency
module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] cal_year,
  input logic [3:0]  cal_month,
  input logic [4:0]  cal_day,
  input logic [4:0]  cal_hour,
  input logic [5:0]  cal_minute,
  input logic [5:0]  cal_second
);

  a_reset_state: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a conversion is running");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_day >= 5'd1)
                  && (cal_hour <= 5'd23) && (cal_minute <= 6'd59) && (cal_second <= 6'd59))
    else $error("calendar field out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cal_year) && $stable(cal_month)
                                && $stable(cal_day) && $stable(cal_hour)
                                && $stable(cal_minute) && $stable(cal_second))
    else $error("stalled result changed");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cal_year   (cal_year),
  .cal_month  (cal_month),
  .cal_day    (cal_day),
  .cal_hour   (cal_hour),
  .cal_minute (cal_minute),
  .cal_second (cal_second)
);

@@ tb/epoch_seconds_to_calendar_core_tb.sv @@
`timescale 1ns / 100ps
// epoch_seconds_to_calendar_core_tb: self-checking bench for the seconds to calendar converter
// holds a calendar predictor in a scoreboard class, plain tasks that drive the input handshake
// and a process that drives out_ready; depends only on epoch_seconds_to_calendar_core
module epoch_seconds_to_calendar_core_tb;

  class calendar_scoreboard;
    localparam longint unsigned SECS_PER_DAY  = 86400;
    localparam longint unsigned SECS_PER_HOUR = 3600;
    localparam longint unsigned SECS_PER_MIN  = 60;
    localparam int unsigned     FIRST_YEAR    = 1970;
    localparam int unsigned     MAX_REPORTS   = 40;

    typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
    } cal_t;

    cal_t        expected_dates[$];
    int unsigned noted;
    int unsigned checked;
    int unsigned errors;
    int unsigned reports;
    bit          field_bad;

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function longint unsigned year_secs(int unsigned y);
      return (is_leap(y) ? 64'd366 : 64'd365) * SECS_PER_DAY;
    endfunction

    // m counts from 0 = january
    function longint unsigned month_secs(int unsigned m, int unsigned y);
      int unsigned days;
      case (m)
        1:           days = is_leap(y) ? 29 : 28;
        3, 5, 8, 10: days = 30;
        default:     days = 31;
      endcase
      return longint'(days) * SECS_PER_DAY;
    endfunction

    function cal_t to_calendar(logic [31:0] secs);
      longint unsigned rem;
      int unsigned     yr;
      int unsigned     mon;
      cal_t            r;
      rem = longint'(secs);
      yr  = FIRST_YEAR;
      mon = 0;
      while (rem >= year_secs(yr)) begin
        rem -= year_secs(yr);
        yr++;
      end
      while (mon < 11 && rem >= month_secs(mon, yr)) begin
        rem -= month_secs(mon, yr);
        mon++;
      end
      r.year   = 12'(yr);
      r.month  = 4'(mon + 1);
      r.day    = 5'(rem / SECS_PER_DAY + 1);
      rem      = rem % SECS_PER_DAY;
      r.hour   = 5'(rem / SECS_PER_HOUR);
      rem      = rem % SECS_PER_HOUR;
      r.minute = 6'(rem / SECS_PER_MIN);
      r.second = 6'(rem % SECS_PER_MIN);
      return r;
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    function void note_input(logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
      noted++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        field_bad = 1'b1;
        if (reports < MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
          reports++;
        end
      end
    endfunction

    function void check_result(cal_t got);
      cal_t want;
      if (expected_dates.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          $display("%0t: result with no transfer waiting, expected none, actual %0d-%0d-%0d",
                   $time, got.year, got.month, got.day);
          reports++;
        end
        return;
      end
      want      = expected_dates.pop_front();
      field_bad = 1'b0;
      compare_field("cal_year",   want.year,   got.year);
      compare_field("cal_month",  want.month,  got.month);
      compare_field("cal_day",    want.day,    got.day);
      compare_field("cal_hour",   want.hour,   got.hour);
      compare_field("cal_minute", want.minute, got.minute);
      compare_field("cal_second", want.second, got.second);
      if (field_bad)
        errors++;
      checked++;
    endfunction
  endclass

  localparam int unsigned NUM_RANDOM  = 1900;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;

  calendar_scoreboard sb;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;

  logic [31:0] corner_secs [$] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd2678399, 32'd2678400, 32'd31535999, 32'd31536000,
    32'd68169600, 32'd68255999, 32'd68256000,
    32'd946684799, 32'd951782400, 32'd951868800,
    32'd4107542399, 32'd4107542400,
    32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  epoch_seconds_to_calendar_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cal_year      (cal_year),
    .cal_month     (cal_month),
    .cal_day       (cal_day),
    .cal_hour      (cal_hour),
    .cal_minute    (cal_minute),
    .cal_second    (cal_second)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: short random stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!rx_burst && $urandom_range(199, 0) == 0) begin
      rx_hold   <= $urandom_range(60, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_burst || ($urandom_range(99, 0) < 75);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(epoch_seconds);
      if (out_valid && out_ready)
        sb.check_result({cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_burst)
      return 0;
    r = $urandom_range(99, 0);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(4, 1);
    return $urandom_range(80, 10);
  endfunction

  // a random month start, pushed a little to either side of midnight or back by up to a day
  function automatic logic [31:0] near_month_edge();
    longint unsigned base;
    int unsigned     y;
    int unsigned     m;
    int unsigned     k;
    y    = $urandom_range(2106, 1970);
    m    = $urandom_range(11, 0);
    base = 0;
    for (k = 1970; k < y; k++)
      base += sb.year_secs(k);
    for (k = 0; k < m; k++)
      base += sb.month_secs(k, y);
    case ($urandom_range(2, 0))
      0:       base = base - $urandom_range(3, 1);
      1:       base = base + $urandom_range(2, 0);
      default: base = base - $urandom_range(86400, 1);
    endcase
    return base[31:0];
  endfunction

  task automatic send_secs(input logic [31:0] secs, input int unsigned gap);
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] secs;
    int unsigned i;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_secs[j])
      send_secs(corner_secs[j], pick_gap());
    drain();

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i % 250 == 0) begin
        tx_burst = ($urandom_range(3, 0) == 0);
        rx_burst <= ($urandom_range(3, 0) == 0);
      end
      if (i == 700 || i == 1400)
        drain();
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4: secs = $urandom;
        5, 6, 7:       secs = near_month_edge();
        default:       secs = $urandom_range(31622399, 0);
      endcase
      send_secs(secs, pick_gap());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transfers in, %0d results checked, %0d mismatching",
             sb.noted, sb.checked, sb.errors);
    $display("inputs spanned 1970 to 2106 with month edges, leap days and idle gaps both sides");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/esc_pkg.sv
hw/rtl/esc_ctrl.sv
hw/rtl/esc_dpath.sv
hw/rtl/epoch_seconds_to_calendar_core.sv
hw/rtl/esc_checker.sv
tb/epoch_seconds_to_calendar_core_tb.sv
